// ----- rtl/core/tds_pkg.sv -----
// ----------------------------------------------------------------------------
// tds_pkg
// Shared constants, codes and types of the task dispatch scheduler.
// ----------------------------------------------------------------------------
package tds_pkg;

   localparam int MAX_COMPUTE_SLOTS = 16;
   localparam int MIN_IO_SLOTS      = 4;
   localparam int PRIO_LEVELS       = 3;
   localparam int PRIV_DEPTH        = 8;
   localparam int GLOB_DEPTH        = 64;
   localparam int SLOT_LIMIT        = 32;

   localparam int PRIV_QUEUES = SLOT_LIMIT * PRIO_LEVELS;
   localparam int GLOB_QUEUES = 2 * PRIO_LEVELS;
   localparam int PRIV_WORDS  = PRIV_QUEUES * PRIV_DEPTH;
   localparam int GLOB_WORDS  = GLOB_QUEUES * GLOB_DEPTH;

   localparam int PQ_W  = $clog2(PRIV_QUEUES);
   localparam int GQ_W  = $clog2(GLOB_QUEUES);
   localparam int PA_W  = $clog2(PRIV_WORDS);
   localparam int GA_W  = $clog2(GLOB_WORDS);
   localparam int PH_W  = $clog2(PRIV_DEPTH);
   localparam int PF_W  = $clog2(PRIV_DEPTH) + 1;
   localparam int GH_W  = $clog2(GLOB_DEPTH);
   localparam int GF_W  = $clog2(GLOB_DEPTH) + 1;
   localparam int TAG_W = 16;

   localparam logic [4:0] COUNT_MAX = 5'd31;

   typedef enum logic [1:0] {
      REQ_ENQ      = 2'd0,
      REQ_ENQ_SLOT = 2'd1,
      REQ_FETCH    = 2'd2,
      REQ_DONE     = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      OUT_PRIVATE = 3'd0,
      OUT_GLOBAL  = 3'd1,
      OUT_GRANTED = 3'd2,
      OUT_WAIT    = 3'd3,
      OUT_DONE    = 3'd4,
      OUT_REJECT  = 3'd5
   } outcome_type;

   typedef struct packed {
      outcome_type outcome;
      logic [4:0]  target;
      logic [1:0]  gprio;
      logic        from_global;
   } result_type;

endpackage

// ----- rtl/core/task_dispatch_scheduler.sv -----
// ----------------------------------------------------------------------------
// task_dispatch_scheduler
// Places tasks on idle worker slots or global priority queues and hands them
// out to fetching workers.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive as words on the req_ channel; req_tuser carries the request
// type. Each request yields exactly one response word on the rsp_ channel,
// whose tuser carries the outcome code.
// One request is in flight at a time: a word is accepted, evaluated in the
// next cycle (slot search, pointer and count update, queue RAM access) and
// its response is then loaded into the output register once that register
// is free; no new word is taken until that response has been loaded.
// The response register frees the core as soon as it is loaded; when the
// receiver stalls, the core holds its finished result and stops accepting.
// Reset clears all counts, queue pointers and the round-robin position and
// sets the compute slot count to four. Queue RAM contents are not cleared.
// The compute slot count is written through csr_wr_en. The user must write
// it only while the block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module task_dispatch_scheduler import tds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] task_kind, [2:1] priority_req, [18:3] task_tag, [23:19] thread_index
   input  logic [23:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] target_thread, [20:5] granted_tag, [22:21] granted_priority,
   // [23] from_global
   output logic [23:0] rsp_tdata,
   // [2:0] outcome
   output logic [2:0]  rsp_tuser
);

   logic             res_valid, res_free;
   result_type       res;
   logic             p_wr_en, g_wr_en, p_rd_en, g_rd_en;
   logic [PA_W-1:0]  p_addr_wr, p_addr_rd;
   logic [GA_W-1:0]  g_addr_wr, g_addr_rd;
   logic [TAG_W-1:0] wr_tag, p_rd_data, g_rd_data, tag_sel;
   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff;
   logic [2:0]       rsp_user_ff;

   tds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_req     (req_tuser),
      .in_kind    (req_tdata[0]),
      .in_prio    (req_tdata[2:1]),
      .in_tag     (req_tdata[18:3]),
      .in_slot    (req_tdata[23:19]),
      .res_valid  (res_valid),
      .res_free   (res_free),
      .res        (res),
      .p_wr_en    (p_wr_en),
      .p_addr_wr  (p_addr_wr),
      .g_wr_en    (g_wr_en),
      .g_addr_wr  (g_addr_wr),
      .wr_tag     (wr_tag),
      .p_rd_en    (p_rd_en),
      .p_addr_rd  (p_addr_rd),
      .g_rd_en    (g_rd_en),
      .g_addr_rd  (g_addr_rd)
   );

   tds_ram #(.WIDTH(TAG_W), .DEPTH(PRIV_WORDS)) u_priv_ram (
      .clock  (clock),
      .wr_en  (p_wr_en),
      .wr_addr(p_addr_wr),
      .wr_data(wr_tag),
      .rd_en  (p_rd_en),
      .rd_addr(p_addr_rd),
      .rd_data(p_rd_data)
   );

   tds_ram #(.WIDTH(TAG_W), .DEPTH(GLOB_WORDS)) u_glob_ram (
      .clock  (clock),
      .wr_en  (g_wr_en),
      .wr_addr(g_addr_wr),
      .wr_data(wr_tag),
      .rd_en  (g_rd_en),
      .rd_addr(g_addr_rd),
      .rd_data(g_rd_data)
   );

   assign res_free = !rsp_valid_ff || rsp_tready;
   assign tag_sel  = (res.outcome != OUT_GRANTED) ? '0 :
                     res.from_global ? g_rd_data : p_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_free && res_valid) begin
         rsp_data_ff <= {res.from_global, res.gprio, tag_sel, res.target};
         rsp_user_ff <= res.outcome;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/core/tds_ram.sv -----
// ----------------------------------------------------------------------------
// tds_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/tds_ctrl.sv -----
// ----------------------------------------------------------------------------
// tds_ctrl
// Request sequencer: decodes a word, searches for an idle slot, keeps queue
// pointers and counts, and drives the queue storage RAMs.
// ----------------------------------------------------------------------------
module tds_ctrl import tds_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_req,
   input  logic             in_kind,
   input  logic [1:0]       in_prio,
   input  logic [TAG_W-1:0] in_tag,
   input  logic [4:0]       in_slot,
   output logic             res_valid,
   input  logic             res_free,
   output result_type       res,
   output logic             p_wr_en,
   output logic [PA_W-1:0]  p_addr_wr,
   output logic             g_wr_en,
   output logic [GA_W-1:0]  g_addr_wr,
   output logic [TAG_W-1:0] wr_tag,
   output logic             p_rd_en,
   output logic [PA_W-1:0]  p_addr_rd,
   output logic             g_rd_en,
   output logic [GA_W-1:0]  g_addr_rd
);

   typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DONE} state_type;

   state_type         state_ff;
   logic [4:0]        ncomp_ff;
   req_type_type      op_ff;
   logic              kind_ff;
   logic [1:0]        prio_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [4:0]        slot_ff;
   result_type        res_ff, res_in;
   logic [31:0]       rr_ff, rr_in;

   // Per-slot counts and pointers, one pointer field per priority level.
   logic [4:0]                        count_ff [SLOT_LIMIT];
   logic [4:0]                        count_in [SLOT_LIMIT];
   logic [PRIO_LEVELS-1:0][PH_W-1:0]  phead_ff [SLOT_LIMIT];
   logic [PRIO_LEVELS-1:0][PH_W-1:0]  phead_in [SLOT_LIMIT];
   logic [PRIO_LEVELS-1:0][PF_W-1:0]  pfill_ff [SLOT_LIMIT];
   logic [PRIO_LEVELS-1:0][PF_W-1:0]  pfill_in [SLOT_LIMIT];
   logic [GH_W-1:0]   ghead_ff [GLOB_QUEUES];
   logic [GH_W-1:0]   ghead_in [GLOB_QUEUES];
   logic [GF_W-1:0]   gfill_ff [GLOB_QUEUES];
   logic [GF_W-1:0]   gfill_in [GLOB_QUEUES];
   // Residue of the round-robin count modulo every possible range 1..16.
   logic [3:0]        rres_ff  [MAX_COMPUTE_SLOTS];
   logic [3:0]        rres_in  [MAX_COMPUTE_SLOTS];

   logic [4:0]        comp;
   logic [4:0]        io;
   logic [5:0]        total;
   logic [4:0]        range_sz;
   logic [4:0]        lo;
   logic [3:0]        start;
   logic [15:0]       ok;
   logic              hit;
   logic [3:0]        pick;
   logic              slot_ok;
   logic              kind_sel;

   assign comp = (ncomp_ff == 5'd0) ? 5'd1 :
                 (ncomp_ff > 5'(MAX_COMPUTE_SLOTS)) ? 5'(MAX_COMPUTE_SLOTS) : ncomp_ff;
   assign io       = (comp > 5'(MIN_IO_SLOTS)) ? comp : 5'(MIN_IO_SLOTS);
   assign total    = {1'b0, comp} + {1'b0, io};
   assign range_sz = kind_ff ? io : comp;
   assign lo       = kind_ff ? comp : 5'd0;
   assign start    = rres_ff[4'(range_sz - 5'd1)];
   assign slot_ok  = {1'b0, slot_ff} < total;
   assign kind_sel = (slot_ff < comp) ? 1'b0 : 1'b1;

   function automatic logic [PQ_W-1:0] pq(input logic [4:0] s, input logic [1:0] p);
      pq = PQ_W'(s) * PQ_W'(PRIO_LEVELS) + PQ_W'(p);
   endfunction

   function automatic logic [GQ_W-1:0] gq(input logic k, input logic [1:0] p);
      gq = GQ_W'(k) * GQ_W'(PRIO_LEVELS) + GQ_W'(p);
   endfunction

   // Idle-slot search, rotated to begin at the round-robin start slot.
   always_comb begin
      logic [4:0] s;
      ok = '0;
      for (int j = 0; j < MAX_COMPUTE_SLOTS; j++) begin
         s = lo + 5'(j);
         ok[j] = (5'(j) < range_sz) && (count_ff[s] == 5'd0) &&
                 (pfill_ff[s][prio_ff] < PF_W'(PRIV_DEPTH));
      end
      hit  = 1'b0;
      pick = '0;
      for (int j = MAX_COMPUTE_SLOTS - 1; j >= 0; j--) begin
         if (ok[j] && 4'(j) >= start) begin
            hit  = 1'b1;
            pick = 4'(j);
         end
      end
      if (!hit) begin
         for (int j = MAX_COMPUTE_SLOTS - 1; j >= 0; j--) begin
            if (ok[j]) begin
               hit  = 1'b1;
               pick = 4'(j);
            end
         end
      end
   end

   always_comb begin
      logic [4:0]      s;
      logic [PQ_W-1:0] q;
      logic [GQ_W-1:0] g;
      logic            gany, got, glob;
      logic [1:0]      gp;
      count_in  = count_ff;
      phead_in  = phead_ff;
      pfill_in  = pfill_ff;
      ghead_in  = ghead_ff;
      gfill_in  = gfill_ff;
      rres_in   = rres_ff;
      rr_in     = rr_ff;
      res_in    = res_ff;
      p_wr_en   = 1'b0;
      g_wr_en   = 1'b0;
      p_rd_en   = 1'b0;
      g_rd_en   = 1'b0;
      p_addr_wr = '0;
      g_addr_wr = '0;
      p_addr_rd = '0;
      g_addr_rd = '0;
      wr_tag    = tag_ff;
      s = '0; q = '0; g = '0; gany = 1'b0; got = 1'b0; glob = 1'b0; gp = '0;
      if (state_ff == S_EVAL) begin
         res_in.outcome     = OUT_REJECT;
         res_in.target      = slot_ff;
         res_in.gprio       = '0;
         res_in.from_global = 1'b0;
         case (op_ff)
            REQ_ENQ: begin
               rr_in = rr_ff + 32'd1;
               // When the 32-bit count wraps, every residue restarts at zero.
               for (int r = 0; r < MAX_COMPUTE_SLOTS; r++) begin
                  if (rr_ff == '1) begin
                     rres_in[r] = 4'd0;
                  end else begin
                     rres_in[r] = (rres_ff[r] == 4'(r)) ? 4'd0 : rres_ff[r] + 4'd1;
                  end
               end
               res_in.target = lo + 5'(start);
               if (hit) begin
                  s = lo + 5'(pick);
                  q = pq(s, prio_ff);
                  p_wr_en   = 1'b1;
                  p_addr_wr = PA_W'(q) * PA_W'(PRIV_DEPTH) +
                              PA_W'(PH_W'(phead_ff[s][prio_ff] +
                                          PH_W'(pfill_ff[s][prio_ff])));
                  pfill_in[s][prio_ff] = pfill_ff[s][prio_ff] + PF_W'(1);
                  if (count_ff[s] != COUNT_MAX) count_in[s] = count_ff[s] + 5'd1;
                  res_in.outcome = OUT_PRIVATE;
                  res_in.target  = s;
               end else begin
                  g = gq(kind_ff, prio_ff);
                  if (gfill_ff[g] < GF_W'(GLOB_DEPTH)) begin
                     g_wr_en   = 1'b1;
                     g_addr_wr = GA_W'(g) * GA_W'(GLOB_DEPTH) +
                                 GA_W'(GH_W'(ghead_ff[g] + GH_W'(gfill_ff[g])));
                     gfill_in[g]    = gfill_ff[g] + GF_W'(1);
                     res_in.outcome = OUT_GLOBAL;
                  end
               end
            end
            REQ_ENQ_SLOT: begin
               q = pq(slot_ff, prio_ff);
               if (slot_ok && pfill_ff[slot_ff][prio_ff] < PF_W'(PRIV_DEPTH)) begin
                  p_wr_en   = 1'b1;
                  p_addr_wr = PA_W'(q) * PA_W'(PRIV_DEPTH) +
                              PA_W'(PH_W'(phead_ff[slot_ff][prio_ff] +
                                          PH_W'(pfill_ff[slot_ff][prio_ff])));
                  pfill_in[slot_ff][prio_ff] = pfill_ff[slot_ff][prio_ff] + PF_W'(1);
                  if (count_ff[slot_ff] != COUNT_MAX) begin
                     count_in[slot_ff] = count_ff[slot_ff] + 5'd1;
                  end
                  res_in.outcome = OUT_PRIVATE;
               end
            end
            REQ_FETCH: begin
               res_in.outcome = OUT_WAIT;
               if (slot_ok) begin
                  for (int p = 0; p < PRIO_LEVELS; p++) begin
                     if (gfill_ff[gq(kind_sel, 2'(p))] != '0) gany = 1'b1;
                  end
                  // Global work wins a level unless that level's global queue is
                  // empty and the slot itself is busy with private work there.
                  for (int p = 0; p < PRIO_LEVELS; p++) begin
                     if (gany && !got) begin
                        if (gfill_ff[gq(kind_sel, 2'(p))] != '0) begin
                           got = 1'b1; glob = 1'b1; gp = 2'(p);
                        end else if (count_ff[slot_ff] != 5'd0 &&
                                     pfill_ff[slot_ff][2'(p)] != '0) begin
                           got = 1'b1; gp = 2'(p);
                        end
                     end
                  end
                  for (int p = 0; p < PRIO_LEVELS; p++) begin
                     if (!got && pfill_ff[slot_ff][2'(p)] != '0) begin
                        got = 1'b1; gp = 2'(p);
                     end
                  end
                  if (got) begin
                     res_in.outcome     = OUT_GRANTED;
                     res_in.gprio       = gp;
                     res_in.from_global = glob;
                     if (glob) begin
                        g = gq(kind_sel, gp);
                        g_rd_en     = 1'b1;
                        g_addr_rd   = GA_W'(g) * GA_W'(GLOB_DEPTH) + GA_W'(ghead_ff[g]);
                        ghead_in[g] = ghead_ff[g] + GH_W'(1);
                        gfill_in[g] = gfill_ff[g] - GF_W'(1);
                        if (count_ff[slot_ff] != COUNT_MAX) begin
                           count_in[slot_ff] = count_ff[slot_ff] + 5'd1;
                        end
                     end else begin
                        q = pq(slot_ff, gp);
                        p_rd_en   = 1'b1;
                        p_addr_rd = PA_W'(q) * PA_W'(PRIV_DEPTH) +
                                    PA_W'(phead_ff[slot_ff][gp]);
                        phead_in[slot_ff][gp] = phead_ff[slot_ff][gp] + PH_W'(1);
                        pfill_in[slot_ff][gp] = pfill_ff[slot_ff][gp] - PF_W'(1);
                     end
                  end
               end
            end
            default: begin
               res_in.outcome = OUT_DONE;
               if (slot_ok && count_ff[slot_ff] != 5'd0) begin
                  count_in[slot_ff] = count_ff[slot_ff] - 5'd1;
               end
            end
         endcase
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ncomp_ff <= 5'd4;
         rr_ff    <= '0;
         for (int i = 0; i < SLOT_LIMIT; i++) begin
            count_ff[i] <= '0;
            phead_ff[i] <= '0;
            pfill_ff[i] <= '0;
         end
         for (int i = 0; i < GLOB_QUEUES; i++) begin
            ghead_ff[i] <= '0;
            gfill_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_COMPUTE_SLOTS; i++) rres_ff[i] <= '0;
      end else begin
         if (csr_wr_en) ncomp_ff <= csr_wr_data;
         count_ff <= count_in;
         phead_ff <= phead_in;
         pfill_ff <= pfill_in;
         ghead_ff <= ghead_in;
         gfill_ff <= gfill_in;
         rres_ff  <= rres_in;
         rr_ff    <= rr_in;
         res_ff   <= res_in;
         case (state_ff)
            S_IDLE: begin
               if (in_valid) state_ff <= S_EVAL;
            end
            S_EVAL: state_ff <= S_DONE;
            S_DONE: begin
               if (res_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && in_valid) begin
         op_ff   <= req_type_type'(in_req);
         kind_ff <= in_kind;
         prio_ff <= (in_prio >= 2'(PRIO_LEVELS)) ? 2'(PRIO_LEVELS - 1) : in_prio;
         tag_ff  <= in_tag;
         slot_ff <= in_slot;
      end
   end

endmodule
